@@ rtl/cld_pkg.sv @@
// ---------------------------------------------------------------------------
// cld_pkg: shared types and constants of the content-length deframer
// Character codes, the header name key, value parser phases, result kinds
// and the event that the header parser hands to the top level.
// ---------------------------------------------------------------------------
package cld_pkg;

    // character codes
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // length of the header name key, in characters
    localparam logic [3:0] NAME_LEN = 4'd14;

    // terminator tracking: CR, CR LF, CR LF CR seen
    localparam logic [1:0] TERM_NONE   = 2'd0;
    localparam logic [1:0] TERM_CR     = 2'd1;
    localparam logic [1:0] TERM_CRLF   = 2'd2;
    localparam logic [1:0] TERM_CRLFCR = 2'd3;

    typedef enum logic [1:0] {
        VP_SKIP   = 2'd0,
        VP_DIGITS = 2'd1,
        VP_DONE   = 2'd2,
        VP_BAD    = 2'd3
    } t_vphase;

    typedef enum logic [1:0] {
        KIND_BODY  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_DROP  = 2'd2
    } t_kind;

    // header parser to top level, valid for the byte being transferred
    typedef struct packed {
        logic done;       // this byte completes CR LF CR LF
        logic len_valid;  // a valid length is held at header end
    } t_hdr_evt;

    // lower-case header name "content-length"
    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] c;
        c = 8'h00;
        case (idx)
            4'd0:    c = 8'h63; // c
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h6C; // l
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // space, TAB, LF, VT, FF, CR
    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

endpackage

@@ rtl/cld_if.sv @@
// ---------------------------------------------------------------------------
// cld_if: stream channels of the content-length deframer
// Input byte channel and result channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface cld_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface cld_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] body_byte;
    logic       last_of_message;

    modport source (output valid, output result_kind, output body_byte,
                    output last_of_message, input ready);
    modport sink   (input valid, input result_kind, input body_byte,
                    input last_of_message, output ready);
endinterface

@@ rtl/cld_hdr_parser.sv @@
// ---------------------------------------------------------------------------
// cld_hdr_parser: header block parser
// Splits header lines at CR LF, matches the content-length name, parses the
// decimal value and flags the CR LF CR LF header end, one byte per i_en cycle.
// ---------------------------------------------------------------------------
module cld_hdr_parser
    import cld_pkg::*;
#(
    parameter int LENGTH_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic [7:0]             i_byte,
    output t_hdr_evt               o_evt,
    output logic [LENGTH_BITS-1:0] o_length
);

    localparam int ProdW = LENGTH_BITS + 4;

    typedef struct packed {
        logic                   colon;
        logic [3:0]             pos;
        logic                   match;
        t_vphase                vphase;
        logic [LENGTH_BITS-1:0] acc;
    } t_line;

    function automatic t_line line_clear();
        t_line s;
        s.colon  = 1'b0;
        s.pos    = '0;
        s.match  = 1'b1;
        s.vphase = VP_SKIP;
        s.acc    = '0;
        return s;
    endfunction

    // one ordinary line character
    function automatic t_line char_step(input t_line s, input logic [7:0] c);
        t_line            r;
        logic [7:0]       lc;
        logic [ProdW-1:0] prod;
        r    = s;
        lc   = ((c >= CH_UP_A) && (c <= CH_UP_Z)) ? (c + CASE_OFS) : c;
        prod = ({4'b0, s.acc} << 3) + ({4'b0, s.acc} << 1)
             + ProdW'(c - CH_0);
        if (!s.colon) begin
            if (c == CH_COLON) begin
                r.colon = 1'b1;
                if (s.pos != NAME_LEN) r.match = 1'b0;
            end else if (s.pos >= NAME_LEN) begin
                // overlong name saturates one past the key length
                r.match = 1'b0;
                r.pos   = NAME_LEN + 4'd1;
            end else begin
                if (lc != key_char(s.pos)) r.match = 1'b0;
                r.pos = s.pos + 4'd1;
            end
        end else if (s.vphase == VP_SKIP) begin
            if (is_digit(c)) begin
                r.acc    = LENGTH_BITS'(c - CH_0);
                r.vphase = VP_DIGITS;
            end else if (!is_space(c)) begin
                r.vphase = VP_BAD;
            end
        end else if (s.vphase == VP_DIGITS) begin
            if (!is_digit(c)) begin
                r.vphase = VP_DONE;
            end else if (prod[ProdW-1:LENGTH_BITS] != 4'b0) begin
                r.vphase = VP_BAD;   // overflows the length width
            end else begin
                r.acc = prod[LENGTH_BITS-1:0];
            end
        end
        return r;
    endfunction

    t_line                  r_line, n_line, line_tmp;
    logic                   r_crp, n_crp;
    logic [1:0]             r_term, n_term;
    logic                   r_len_valid, n_len_valid;
    logic [LENGTH_BITS-1:0] r_body_len, n_body_len;
    logic                   done;
    logic                   lv_at_end;

    // line and terminator update for one header byte
    always_comb begin
        n_line      = r_line;
        n_crp       = r_crp;
        n_term      = r_term;
        n_len_valid = r_len_valid;
        n_body_len  = r_body_len;
        line_tmp    = r_line;
        done        = 1'b0;
        if (i_en) begin
            if (r_crp && (i_byte == CH_LF)) begin
                // line end: a matching name takes or clears the length
                if (r_line.colon && r_line.match) begin
                    if ((r_line.vphase == VP_DIGITS) || (r_line.vphase == VP_DONE)) begin
                        n_len_valid = 1'b1;
                        n_body_len  = r_line.acc;
                    end else begin
                        n_len_valid = 1'b0;
                    end
                end
                n_line = line_clear();
                n_crp  = 1'b0;
            end else begin
                // a held CR that is not part of CR LF is a line character
                line_tmp = r_crp ? char_step(r_line, CH_CR) : r_line;
                n_crp    = (i_byte == CH_CR);
                n_line   = (i_byte == CH_CR) ? line_tmp : char_step(line_tmp, i_byte);
            end

            if (i_byte == CH_CR) begin
                n_term = (r_term == TERM_CRLF) ? TERM_CRLFCR : TERM_CR;
            end else if (i_byte == CH_LF) begin
                done   = (r_term == TERM_CRLFCR);
                n_term = (r_term == TERM_CR) ? TERM_CRLF : TERM_NONE;
            end else begin
                n_term = TERM_NONE;
            end
        end
        lv_at_end = n_len_valid;
        if (done) begin
            n_term      = TERM_NONE;
            n_crp       = 1'b0;
            n_line      = line_clear();
            n_len_valid = 1'b0;
        end
    end

    assign o_evt.done      = done;
    assign o_evt.len_valid = lv_at_end;
    assign o_length        = n_body_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line      <= line_clear();
            r_crp       <= 1'b0;
            r_term      <= TERM_NONE;
            r_len_valid <= 1'b0;
            r_body_len  <= '0;
        end else begin
            r_line      <= n_line;
            r_crp       <= n_crp;
            r_term      <= n_term;
            r_len_valid <= n_len_valid;
            r_body_len  <= n_body_len;
        end
    end

endmodule

@@ rtl/content_length_deframer.sv @@
// ---------------------------------------------------------------------------
// content_length_deframer: header-then-body stream deframer
// Strips content-length framed headers and passes the body bytes on.
// ---------------------------------------------------------------------------
// Usage:
//   i_in carries one raw stream byte per transfer. o_out carries at most one
//   result per input byte: a body byte (kind 0, last_of_message on the final
//   byte), an empty-message marker (kind 1) for length zero, or a drop
//   marker (kind 2) when the header ends without a valid content-length.
//   Header bytes other than the final LF give no result.
// Latency: a result appears on o_out the cycle after its byte is taken.
// Throughput: one byte per cycle in header and body alike when not stalled;
//   each byte passes through one stage of name/value parsing (a shift-add
//   times-ten step on the length accumulator) into the output register.
// Stall: the output register holds its result while o_out.ready is low;
//   i_in.ready is low only while that register is full and not being taken,
//   so a byte is taken in the same cycle as the waiting result leaves.
// Reset: synchronous, active low; the block restarts in header parsing with
//   no length held and no result pending.
// ---------------------------------------------------------------------------
module content_length_deframer
    import cld_pkg::*;
#(
    parameter int LENGTH_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cld_in_if.sink    i_in,
    cld_out_if.source o_out
);

    t_hdr_evt               hdr_evt;
    logic [LENGTH_BITS-1:0] hdr_length;

    logic                   in_ready;
    logic                   in_xfer;
    logic                   hdr_en;

    logic                   r_phase, n_phase;
    logic [LENGTH_BITS-1:0] r_rem, n_rem;

    logic                   res_valid;
    t_kind                  res_kind;
    logic [7:0]             res_byte;
    logic                   res_last;

    logic                   r_out_valid;
    t_kind                  r_out_kind;
    logic [7:0]             r_out_byte;
    logic                   r_out_last;

    // input side: free when the output register is empty or drains now
    assign in_ready   = !r_out_valid || o_out.ready;
    assign in_xfer    = i_in.valid && in_ready;
    assign hdr_en     = in_xfer && !r_phase;
    assign i_in.ready = in_ready;

    cld_hdr_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_hdr_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (hdr_en),
        .i_byte   (i_in.in_byte),
        .o_evt    (hdr_evt),
        .o_length (hdr_length)
    );

    // body pass-through and header-end decision
    always_comb begin
        n_phase   = r_phase;
        n_rem     = r_rem;
        res_valid = 1'b0;
        res_kind  = KIND_BODY;
        res_byte  = 8'h00;
        res_last  = 1'b0;
        if (in_xfer) begin
            if (r_phase) begin
                res_valid = 1'b1;
                res_byte  = i_in.in_byte;
                res_last  = (r_rem[LENGTH_BITS-1:1] == '0);
                if (r_rem != '0) n_rem = r_rem - LENGTH_BITS'(1);
                if (n_rem == '0) n_phase = 1'b0;
            end else if (hdr_evt.done) begin
                if (!hdr_evt.len_valid) begin
                    res_valid = 1'b1;
                    res_kind  = KIND_DROP;
                end else if (hdr_length == '0) begin
                    res_valid = 1'b1;
                    res_kind  = KIND_EMPTY;
                    res_last  = 1'b1;
                end else begin
                    n_rem   = hdr_length;
                    n_phase = 1'b1;
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 1'b0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_rem   <= n_rem;
            if (in_xfer) begin
                r_out_valid <= res_valid;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_kind <= res_kind;
            r_out_byte <= res_byte;
            r_out_last <= res_last;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.result_kind     = 2'(r_out_kind);
    assign o_out.body_byte       = r_out_byte;
    assign o_out.last_of_message = r_out_last;

endmodule

@@ rtl/cld_checker.sv @@
// ---------------------------------------------------------------------------
// cld_checker: port-level checks for the content-length deframer
// Watches the result channel and reset behavior; bound to the top level.
// ---------------------------------------------------------------------------
module cld_checker
    import cld_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_result_kind,
    input logic [7:0] i_body_byte,
    input logic       i_last
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_result_kind) && $stable(i_body_byte) && $stable(i_last))
        else $error("result changed while stalled");

    // reset leaves no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // only defined result kinds are shown
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_result_kind == KIND_BODY) || (i_result_kind == KIND_EMPTY)
                     || (i_result_kind == KIND_DROP))
        else $error("undefined result kind");

    // marker results carry no byte
    a_marker_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_result_kind != KIND_BODY) |-> (i_body_byte == 8'h00))
        else $error("marker result with nonzero byte");

    // empty message always ends a message, a drop never does
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_result_kind != KIND_BODY) |->
            (i_last == (i_result_kind == KIND_EMPTY)))
        else $error("wrong end-of-message flag on marker");

endmodule

bind content_length_deframer cld_checker u_cld_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_result_kind (o_out.result_kind),
    .i_body_byte   (o_out.body_byte),
    .i_last        (o_out.last_of_message)
);

@@ sim/content_length_deframer_test.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// content_length_deframer_test: self-checking testbench of the deframer
// Feeds header-then-body framed byte streams through the input channel,
// predicts every result in a behavioral copy of the parser and compares
// each transfer on the result channel field by field. Directed messages
// cover value syntax, name matching and length precedence, then random
// framed messages with noise run under random sender and receiver idling.
// ---------------------------------------------------------------------------
module content_length_deframer_test;
    import cld_pkg::*;

    localparam int          LEN_BITS     = 32;
    localparam logic [63:0] LEN_MAX      = (64'd1 << LEN_BITS) - 64'd1;
    localparam int          KEY_LEN      = 14;
    localparam logic [8*KEY_LEN-1:0] LENGTH_KEY = "content-length";
    localparam logic [7:0]  ASCII_CR     = 8'h0D;
    localparam logic [7:0]  ASCII_LF     = 8'h0A;
    localparam int          RANDOM_BYTES = 400;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          DRAIN_CYCLES = 16;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       is_last;
    } msg_result_t;

    typedef enum int {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_PERIODIC,
        SINK_LONG_STALL
    } sink_mode_e;

    logic clk;
    logic rst_n;

    cld_in_if  in_ch ();
    cld_out_if out_ch ();

    content_length_deframer #(
        .LENGTH_BITS(LEN_BITS)
    ) DUT (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    msg_result_t expected_results[$];
    int          fail_count  = 0;
    int          bytes_sent  = 0;
    int          burst_left  = 0;

    // predicted parser state, at its reset values
    logic        in_body     = 1'b0;
    logic [1:0]  term_state  = TERM_NONE;
    logic        cr_held     = 1'b0;
    logic        colon_found = 1'b0;
    logic [3:0]  name_idx    = 4'd0;
    logic        name_ok     = 1'b1;
    t_vphase     val_state   = VP_SKIP;
    logic [63:0] val_acc     = 64'd0;
    logic        len_known   = 1'b0;
    logic [63:0] msg_len     = 64'd0;
    logic [63:0] body_left   = 64'd0;

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // -----------------------------------------------------------------------
    // Prediction
    // -----------------------------------------------------------------------
    function automatic void clear_line_state();
        colon_found = 1'b0;
        name_idx    = 4'd0;
        name_ok     = 1'b1;
        val_state   = VP_SKIP;
        val_acc     = 64'd0;
    endfunction

    // one character of a header line, CR LF already stripped
    function automatic void parse_line_char(input logic [7:0] c);
        logic [7:0]  lc;
        logic [63:0] digit;
        int          pos;
        if (!colon_found) begin
            if (c == ":") begin
                colon_found = 1'b1;
                if (name_idx != KEY_LEN) name_ok = 1'b0;
            end else if (name_idx >= KEY_LEN) begin
                // name too long, position saturates one past the key
                name_ok  = 1'b0;
                name_idx = 4'(KEY_LEN + 1);
            end else begin
                lc  = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
                pos = KEY_LEN - 1 - int'(name_idx);
                if (lc != LENGTH_KEY[8*pos +: 8]) name_ok = 1'b0;
                name_idx = name_idx + 4'd1;
            end
        end else begin
            case (val_state)
                VP_SKIP: begin
                    if (!(c == " " || (c >= 8'h09 && c <= 8'h0D))) begin
                        if (c >= "0" && c <= "9") begin
                            val_acc   = 64'(c - "0");
                            val_state = VP_DIGITS;
                        end else begin
                            val_state = VP_BAD;
                        end
                    end
                end
                VP_DIGITS: begin
                    if (c >= "0" && c <= "9") begin
                        digit = 64'(c - "0");
                        if (val_acc > (LEN_MAX - digit) / 64'd10) val_state = VP_BAD;
                        else val_acc = val_acc * 64'd10 + digit;
                    end else begin
                        val_state = VP_DONE;
                    end
                end
                default: ;
            endcase
        end
    endfunction

    // advance the prediction by one accepted byte; returns 1 with a result
    function automatic bit deframe_byte(input logic [7:0] b, output msg_result_t r);
        bit hdr_done;
        r.kind    = KIND_BODY;
        r.data    = 8'h00;
        r.is_last = 1'b0;

        // body bytes pass through unparsed
        if (in_body) begin
            r.data    = b;
            r.is_last = (body_left <= 64'd1);
            if (body_left > 64'd0) body_left = body_left - 64'd1;
            if (body_left == 64'd0) in_body = 1'b0;
            return 1'b1;
        end

        // line splitting: a CR is held until it is known not to start CR LF
        if (cr_held && b == ASCII_LF) begin
            if (colon_found && name_ok) begin
                if (val_state == VP_DIGITS || val_state == VP_DONE) begin
                    len_known = 1'b1;
                    msg_len   = val_acc & LEN_MAX;
                end else begin
                    len_known = 1'b0;
                end
            end
            clear_line_state();
            cr_held = 1'b0;
        end else begin
            if (cr_held) parse_line_char(ASCII_CR);
            cr_held = (b == ASCII_CR);
            if (!cr_held) parse_line_char(b);
        end

        // header terminator tracking
        hdr_done = 1'b0;
        if (b == ASCII_CR) begin
            term_state = (term_state == TERM_CRLF) ? TERM_CRLFCR : TERM_CR;
        end else if (b == ASCII_LF) begin
            hdr_done   = (term_state == TERM_CRLFCR);
            term_state = (term_state == TERM_CR) ? TERM_CRLF : TERM_NONE;
        end else begin
            term_state = TERM_NONE;
        end
        if (!hdr_done) return 1'b0;

        // header end
        term_state = TERM_NONE;
        cr_held    = 1'b0;
        clear_line_state();
        if (!len_known) begin
            r.kind = KIND_DROP;
            return 1'b1;
        end
        len_known = 1'b0;
        if (msg_len == 64'd0) begin
            r.kind    = KIND_EMPTY;
            r.is_last = 1'b1;
            return 1'b1;
        end
        body_left = msg_len;
        in_body   = 1'b1;
        return 1'b0;
    endfunction

    // -----------------------------------------------------------------------
    // Byte sender: bursts of random length separated by random gaps
    // -----------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        msg_result_t res;
        int          gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge clk);
                in_ch.valid   = 1'b0;
                in_ch.in_byte = 8'($urandom_range(0, 255));
            end
        end
        @(negedge clk);
        in_ch.valid   = 1'b1;
        in_ch.in_byte = b;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        if (deframe_byte(b, res)) expected_results.insert(expected_results.size(), res);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // bytes that stress the parser more than uniform ones
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 5))
            0:       return ASCII_CR;
            1:       return ASCII_LF;
            2:       return ":";
            3:       return 8'("0" + $urandom_range(0, 9));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // content-length line in random case, with a good or a broken value
    task automatic send_length_line(input bit broken);
        logic [7:0] c;
        int         n;
        for (int i = 0; i < KEY_LEN; i++) begin
            c = LENGTH_KEY[8*(KEY_LEN-1-i) +: 8];
            if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) c = c - 8'd32;
            send_byte(c);
        end
        send_byte(":");
        n = $urandom_range(0, 2);
        repeat (n) begin
            case ($urandom_range(0, 4))
                0:       send_byte(8'h09);
                1:       send_byte(8'h0B);
                2:       send_byte(8'h0C);
                default: send_byte(" ");
            endcase
        end
        if (!broken) begin
            if ($urandom_range(0, 5) == 0) send_byte("0");
            if ($urandom_range(0, 7) == 0) send_text($sformatf("%0d", $urandom_range(13, 40)));
            else send_text($sformatf("%0d", $urandom_range(0, 12)));
            if ($urandom_range(0, 4) == 0) send_text(" ;x");
        end else begin
            case ($urandom_range(0, 4))
                0:       send_text($sformatf("+%0d", $urandom_range(0, 9)));
                1:       send_text($sformatf("-%0d", $urandom_range(0, 9)));
                2:       send_text("abc");
                3:       send_text("99999999999");
                default: ;
            endcase
        end
        send_byte(ASCII_CR);
        send_byte(ASCII_LF);
    endtask

    // some other header line; now and then another length line
    task automatic send_other_line();
        int n;
        if ($urandom_range(0, 5) == 0) begin
            send_length_line($urandom_range(0, 3) == 0);
        end else begin
            n = $urandom_range(1, 10);
            repeat (n) begin
                if ($urandom_range(0, 7) == 0) send_byte("-");
                else send_byte(8'(($urandom_range(0, 1) ? "a" : "A") + $urandom_range(0, 25)));
            end
            send_byte(":");
            n = $urandom_range(0, 8);
            repeat (n) send_byte(8'($urandom_range(32, 126)));
            send_byte(ASCII_CR);
            send_byte(ASCII_LF);
        end
    endtask

    // -----------------------------------------------------------------------
    // Result checking
    // -----------------------------------------------------------------------
    always @(posedge clk) begin : result_check
        msg_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: result_kind %0d body_byte 0x%02h last_of_message %0b",
                       out_ch.result_kind, out_ch.body_byte, out_ch.last_of_message);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (out_ch.result_kind !== want.kind) begin
                    $error("result_kind: expected %0d, actual %0d",
                           want.kind, out_ch.result_kind);
                    fail_count++;
                end
                if (out_ch.body_byte !== want.data) begin
                    $error("body_byte: expected 0x%02h, actual 0x%02h",
                           want.data, out_ch.body_byte);
                    fail_count++;
                end
                if (out_ch.last_of_message !== want.is_last) begin
                    $error("last_of_message: expected %0b, actual %0b",
                           want.is_last, out_ch.last_of_message);
                    fail_count++;
                end
            end
        end
    end

    // result receiver: stall pattern switches among open, random, periodic and long-stall modes
    initial begin : result_sink
        sink_mode_e mode;
        int         span;
        int         stall_left;
        int         tick;
        out_ch.ready = 1'b0;
        stall_left   = 0;
        tick         = 0;
        forever begin
            mode = sink_mode_e'($urandom_range(0, 3));
            span = $urandom_range(16, 160);
            repeat (span) begin
                @(negedge clk);
                tick++;
                case (mode)
                    SINK_OPEN:     out_ch.ready = 1'b1;
                    SINK_RANDOM:   out_ch.ready = ($urandom_range(0, 2) != 0);
                    SINK_PERIODIC: out_ch.ready = ((tick % 7) < 4);
                    default: begin
                        if (stall_left > 0) begin
                            out_ch.ready = 1'b0;
                            stall_left--;
                        end else begin
                            out_ch.ready = 1'b1;
                            if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(4, 20);
                        end
                    end
                endcase
            end
        end
    end

    // watchdog: too many cycles without any transfer ends the run
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL content_length_deframer");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------
    // plain message, empty message, header without lines, byte extremes in body
    task automatic test_basic_framing();
        send_text("Content-Length: 3\015\012\015\012a\015\012");
        send_text("CONTENT-length:0\015\012\015\012");
        send_text("\015\012\015\012");
        send_text("Content-Length: 2\015\012\015\012");
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    // whitespace, lone CR or LF before digits, signs, missing digits
    task automatic test_value_syntax();
        send_text("content-length:\011\013\014 2xyz\015\012\015\012hi");
        send_text("Content-Length:\0155\015\012\015\01212345");
        send_text("Content-Length:\0121\015\012\015\012Q");
        send_text("Content-Length: +4\015\012\015\012");
        send_text("Content-Length: -4\015\012\015\012");
        send_text("Content-Length:\015\012\015\012");
        send_text("Content-Length: 1\015\015\012\015\012B");
    endtask

    // last valid line wins, bad line clears, overflow, leading zeros
    task automatic test_length_precedence();
        send_text("Content-Length: 4294967295\015\012Content-Length: 1\015\012\015\012Z");
        send_text("Content-Length: 4294967296\015\012\015\012");
        send_text("Content-Length: 2\015\012Content-Length: x\015\012\015\012");
        send_text("Content-Length: 1\015\012X-Other: 7\015\012\015\012Q");
        send_text("Content-Length: 007\015\012\015\0121234567");
    endtask

    // long names, lone CR in name, empty name, no colon, odd bytes in name
    task automatic test_header_names();
        send_text("Content-LengthX: 1\015\012\015\012");
        send_text("content-length-and-more: 1\015\012\015\012");
        send_text("Content\015-Length: 1\015\012\015\012");
        send_text(": 1\015\012\015\012");
        send_text("Content-Length 1\015\012\015\012");
        send_text("Content_Length: 1\015\012\015\012");
        send_text("Content-Length: 1:2\015\012\015\012A");
        send_text("CoNtEnT-LeNgTh: 1\015\012\015\012m");
        send_byte("X");
        send_byte(8'hFF);
        send_byte(8'h00);
        send_text(": 1\015\012\015\012");
    endtask

    // random framed messages, some broken, some plain noise
    task automatic test_random_stream();
        int stop_at;
        int shape;
        int n_other;
        int len_line;
        int n;
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at) begin
            shape = $urandom_range(0, 15);
            if (shape == 0) begin
                n = $urandom_range(1, 16);
                repeat (n) send_byte(noise_byte());
            end else begin
                n_other  = $urandom_range(0, 2);
                len_line = $urandom_range(0, n_other);
                for (int i = 0; i <= n_other; i++) begin
                    if (i == len_line && shape != 1) send_length_line(shape <= 3);
                    else send_other_line();
                end
                send_byte(ASCII_CR);
                send_byte(ASCII_LF);
            end
            // whatever body the block now expects, random content
            while (in_body) begin
                if ($urandom_range(0, 3) == 0) send_byte(noise_byte());
                else send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin : stimulus
        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'h00;
        rst_n         = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_basic_framing();
        test_value_syntax();
        test_length_precedence();
        test_header_names();
        test_random_stream();

        @(negedge clk);
        in_ch.valid = 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("PASS content_length_deframer");
        end else begin
            $display("FAIL content_length_deframer");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/cld_pkg.sv
rtl/cld_if.sv
rtl/cld_hdr_parser.sv
rtl/content_length_deframer.sv
rtl/cld_checker.sv
sim/content_length_deframer_test.sv
